[src/chgsup_pkg.sv]
// Shared types, codes and constants for the charge supervisor block.
// Used by chgsup_ctrl, chgsup_datapath and charge_supervisor; no dependencies.
`default_nettype none

package chgsup_pkg;

    // Stream and configuration port widths.
    localparam int IN_W   = 112;
    localparam int OUT_W  = 232;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_RETRY_INTERVAL  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_WATCHDOG_INTVL  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ENERGY_GAP_LIM  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_IN1_MIN         = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SIX_IN2_MIN     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_THREE_IN2_MIN   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_THREE_IN2_MAX   = 3'd6;

    // Register reset values.
    localparam logic [31:0] RST_RETRY_INTERVAL = 32'd5000;
    localparam logic [31:0] RST_WATCHDOG_INTVL = 32'd1000;
    localparam logic [31:0] RST_ENERGY_GAP_LIM = 32'd5000;
    localparam logic [15:0] RST_IN1_MIN        = 16'd10000;
    localparam logic [15:0] RST_SIX_IN2_MIN    = 16'd18000;
    localparam logic [15:0] RST_THREE_IN2_MIN  = 16'd9000;
    localparam logic [15:0] RST_THREE_IN2_MAX  = 16'd15000;

    // Charge state codes.
    localparam logic [2:0] SOC_UNKNOWN      = 3'd0;
    localparam logic [2:0] SOC_CHARGING     = 3'd1;
    localparam logic [2:0] SOC_COMPLETED    = 3'd2;
    localparam logic [2:0] SOC_NOT_CHARGING = 3'd3;
    localparam logic [2:0] SOC_FAULT        = 3'd4;

    // Battery profile codes.
    localparam logic [1:0] PROF_NONE  = 2'd0;
    localparam logic [1:0] PROF_THREE = 2'd1;
    localparam logic [1:0] PROF_SIX   = 2'd2;

    // Source bit positions in the updated and valid masks.
    localparam int SRC_STATUS  = 0;
    localparam int SRC_POWER   = 1;
    localparam int SRC_CHARGER = 2;

    localparam logic [62:0] ENERGY_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    // Input item, last declared field in the lowest bits.
    typedef struct packed {
        logic        pad;
        logic        driver_ok;
        logic [15:0] input2_voltage_mv;
        logic [15:0] input1_voltage_mv;
        logic [15:0] output_current_ma;
        logic [15:0] output_voltage_mv;
        logic [7:0]  status_port_byte;
        logic [2:0]  valid_sources;
        logic [2:0]  updated_sources;
        logic [31:0] timestamp_ms;
    } in_item_t;

    // Result item, last declared field in the lowest bits.
    typedef struct packed {
        logic        command_failed;
        logic [62:0] idle_energy;
        logic [62:0] charging_energy;
        logic [62:0] unknown_energy;
        logic [30:0] power_uw;
        logic        watchdog_kick_cmd;
        logic [1:0]  apply_profile_cmd;
        logic [1:0]  configured_profile;
        logic [1:0]  detected_profile;
        logic        charge_indicator;
        logic [2:0]  charge_state;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decode;
        logic mult;
        logic commit;
    } cmd_t;

    // Status port stat1 is bit 5, stat2 is bit 4.
    function automatic logic [2:0] decode_state(input logic [7:0] port_byte);
        logic [1:0] stat;
        stat = {port_byte[5], port_byte[4]};
        case (stat)
            2'b01:   decode_state = SOC_CHARGING;
            2'b10:   decode_state = SOC_COMPLETED;
            2'b11:   decode_state = SOC_NOT_CHARGING;
            default: decode_state = SOC_FAULT;
        endcase
    endfunction

endpackage

`default_nettype wire

[src/chgsup_ctrl.sv]
// Sequencing controller of the charge supervisor: input handshake, the
// decode, multiply and commit steps, and the output valid flag. Uses chgsup_pkg.
`default_nettype none

module chgsup_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output chgsup_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MULT,
        ST_ACCUM
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   commit;

    // The result is committed once the output register is free or being drained.
    assign commit = (state_reg == ST_ACCUM) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: state_next = ST_MULT;
            ST_MULT:   state_next = ST_ACCUM;
            ST_ACCUM:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        m_tvalid_next = commit || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign cmd.load   = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.decode = (state_reg == ST_DECODE);
    assign cmd.mult   = (state_reg == ST_MULT);
    assign cmd.commit = commit;

endmodule

`default_nettype wire

[src/chgsup_datapath.sv]
// Datapath of the charge supervisor: configuration registers, charge state,
// power and energy arithmetic, profile policy and the result register. Uses chgsup_pkg.
`default_nettype none

module chgsup_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [chgsup_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire logic [chgsup_pkg::CFG_DW-1:0]     cfg_wdata,
    input  wire chgsup_pkg::cmd_t                  cmd,
    input  wire chgsup_pkg::in_item_t              in_item,
    output chgsup_pkg::out_item_t                  out_item
);

    // Configuration registers.
    logic [31:0] retry_interval_reg;
    logic [31:0] watchdog_interval_reg;
    logic [31:0] gap_limit_reg;
    logic [15:0] in1_min_reg;
    logic [15:0] six_in2_min_reg;
    logic [15:0] three_in2_min_reg;
    logic [15:0] three_in2_max_reg;

    // Architectural state.
    logic [2:0]  soc_reg;
    logic [1:0]  seen_reg;
    logic [1:0]  applied_reg;
    logic        have_time_reg;
    logic [31:0] last_power_time_reg;
    logic [31:0] last_attempt_reg;
    logic [31:0] last_kick_reg;
    logic [62:0] unk_energy_reg;
    logic [62:0] chg_energy_reg;
    logic [62:0] idle_energy_reg;
    logic        fail_reg;
    logic [30:0] held_power_reg;

    // Captured item and intermediate stage registers.
    chgsup_pkg::in_item_t item_reg;
    logic [2:0]  soc_new_reg;
    logic [30:0] power_reg;
    logic [31:0] gap_reg;
    logic        gap_ok_reg;
    logic [1:0]  det_reg;
    logic [62:0] energy_reg;
    chgsup_pkg::out_item_t out_reg;

    // Decode step.
    logic        pw_en;
    logic        pol_en;
    logic [2:0]  soc_dec;
    logic [30:0] power_prod;
    logic [31:0] gap_calc;
    logic        gap_ok_calc;
    logic        in1_high;
    logic [1:0]  det_calc;

    // Multiply and commit steps.
    logic [62:0] energy_prod;
    logic [62:0] bin_cur;
    logic [63:0] bin_sum;
    logic [62:0] bin_upd;
    logic [31:0] attempt_gap;
    logic [31:0] kick_gap;
    logic        policy_go;
    logic        apply_go;
    logic        kick_go;
    logic [1:0]  seen_next;
    logic [1:0]  applied_next;
    logic [62:0] unk_energy_next;
    logic [62:0] chg_energy_next;
    logic [62:0] idle_energy_next;
    logic        fail_next;
    logic [30:0] held_power_next;
    chgsup_pkg::out_item_t out_next;

    assign pw_en  = item_reg.updated_sources[chgsup_pkg::SRC_POWER]
                 && item_reg.valid_sources[chgsup_pkg::SRC_POWER];
    assign pol_en = item_reg.valid_sources[chgsup_pkg::SRC_POWER];

    always_comb
    begin
        soc_dec = soc_reg;
        if (item_reg.updated_sources[chgsup_pkg::SRC_STATUS])
        begin
            if (item_reg.valid_sources[chgsup_pkg::SRC_STATUS])
            begin
                soc_dec = chgsup_pkg::decode_state(item_reg.status_port_byte);
            end
            else
            begin
                soc_dec = chgsup_pkg::SOC_UNKNOWN;
            end
        end
    end

    // A negative current gives zero power; the positive product stays below 2^31.
    assign power_prod  = item_reg.output_current_ma[15] ? 31'd0
                       : ({15'd0, item_reg.output_voltage_mv}
                          * {16'd0, item_reg.output_current_ma[14:0]});
    assign gap_calc    = item_reg.timestamp_ms - last_power_time_reg;
    assign gap_ok_calc = have_time_reg && (gap_calc != 32'd0) && (gap_calc <= gap_limit_reg);

    assign in1_high = item_reg.input1_voltage_mv > in1_min_reg;
    always_comb
    begin
        if (in1_high && (item_reg.input2_voltage_mv > six_in2_min_reg))
        begin
            det_calc = chgsup_pkg::PROF_SIX;
        end
        else if (in1_high && (item_reg.input2_voltage_mv > three_in2_min_reg)
                 && (item_reg.input2_voltage_mv < three_in2_max_reg))
        begin
            det_calc = chgsup_pkg::PROF_THREE;
        end
        else
        begin
            det_calc = chgsup_pkg::PROF_NONE;
        end
    end

    assign energy_prod = 63'(power_reg) * 63'(gap_reg);

    // Energy goes to the bin of the charge state after this sample's update.
    always_comb
    begin
        case (soc_new_reg)
            chgsup_pkg::SOC_UNKNOWN:  bin_cur = unk_energy_reg;
            chgsup_pkg::SOC_CHARGING: bin_cur = chg_energy_reg;
            default:                  bin_cur = idle_energy_reg;
        endcase
    end

    // Both addends are below 2^63, so bit 63 of the sum flags saturation.
    assign bin_sum = {1'b0, bin_cur} + {1'b0, energy_reg};
    assign bin_upd = bin_sum[63] ? chgsup_pkg::ENERGY_MAX : bin_sum[62:0];

    assign attempt_gap = item_reg.timestamp_ms - last_attempt_reg;
    assign kick_gap    = item_reg.timestamp_ms - last_kick_reg;
    assign policy_go   = pol_en && (det_reg != chgsup_pkg::PROF_NONE)
                      && item_reg.valid_sources[chgsup_pkg::SRC_CHARGER];
    assign apply_go    = policy_go
                      && ((det_reg == chgsup_pkg::PROF_THREE)
                          || (soc_new_reg == chgsup_pkg::SOC_NOT_CHARGING))
                      && (det_reg != applied_reg)
                      && ((last_attempt_reg == 32'd0) || (attempt_gap >= retry_interval_reg));
    assign kick_go     = policy_go && !apply_go
                      && (det_reg == chgsup_pkg::PROF_THREE)
                      && (applied_reg == chgsup_pkg::PROF_THREE)
                      && (kick_gap >= watchdog_interval_reg);

    always_comb
    begin
        seen_next        = seen_reg;
        applied_next     = applied_reg;
        unk_energy_next  = unk_energy_reg;
        chg_energy_next  = chg_energy_reg;
        idle_energy_next = idle_energy_reg;
        fail_next        = fail_reg;
        held_power_next  = held_power_reg;
        if (pw_en)
        begin
            held_power_next = power_reg;
            case (soc_new_reg)
                chgsup_pkg::SOC_UNKNOWN:  unk_energy_next  = bin_upd;
                chgsup_pkg::SOC_CHARGING: chg_energy_next  = bin_upd;
                default:                  idle_energy_next = bin_upd;
            endcase
        end
        if (pol_en)
        begin
            seen_next = det_reg;
            if (det_reg == chgsup_pkg::PROF_NONE)
            begin
                applied_next = chgsup_pkg::PROF_NONE;
            end
        end
        if (apply_go || kick_go)
        begin
            fail_next = !item_reg.driver_ok;
        end
        if (apply_go && item_reg.driver_ok)
        begin
            applied_next = det_reg;
        end
    end

    always_comb
    begin
        out_next.command_failed     = fail_next;
        out_next.idle_energy        = idle_energy_next;
        out_next.charging_energy    = chg_energy_next;
        out_next.unknown_energy     = unk_energy_next;
        out_next.power_uw           = held_power_next;
        out_next.watchdog_kick_cmd  = kick_go;
        out_next.apply_profile_cmd  = apply_go ? det_reg : chgsup_pkg::PROF_NONE;
        out_next.configured_profile = applied_next;
        out_next.detected_profile   = seen_next;
        out_next.charge_indicator   = (soc_new_reg == chgsup_pkg::SOC_CHARGING);
        out_next.charge_state       = soc_new_reg;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_interval_reg    <= chgsup_pkg::RST_RETRY_INTERVAL;
            watchdog_interval_reg <= chgsup_pkg::RST_WATCHDOG_INTVL;
            gap_limit_reg         <= chgsup_pkg::RST_ENERGY_GAP_LIM;
            in1_min_reg           <= chgsup_pkg::RST_IN1_MIN;
            six_in2_min_reg       <= chgsup_pkg::RST_SIX_IN2_MIN;
            three_in2_min_reg     <= chgsup_pkg::RST_THREE_IN2_MIN;
            three_in2_max_reg     <= chgsup_pkg::RST_THREE_IN2_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                chgsup_pkg::REG_RETRY_INTERVAL: retry_interval_reg    <= cfg_wdata;
                chgsup_pkg::REG_WATCHDOG_INTVL: watchdog_interval_reg <= cfg_wdata;
                chgsup_pkg::REG_ENERGY_GAP_LIM: gap_limit_reg         <= cfg_wdata;
                chgsup_pkg::REG_IN1_MIN:        in1_min_reg           <= cfg_wdata[15:0];
                chgsup_pkg::REG_SIX_IN2_MIN:    six_in2_min_reg       <= cfg_wdata[15:0];
                chgsup_pkg::REG_THREE_IN2_MIN:  three_in2_min_reg     <= cfg_wdata[15:0];
                chgsup_pkg::REG_THREE_IN2_MAX:  three_in2_max_reg     <= cfg_wdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Item capture and intermediate stages.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.decode)
        begin
            soc_new_reg <= soc_dec;
            power_reg   <= power_prod;
            gap_reg     <= gap_calc;
            gap_ok_reg  <= gap_ok_calc;
            det_reg     <= det_calc;
        end
        if (cmd.mult)
        begin
            energy_reg <= (pw_en && gap_ok_reg) ? energy_prod : 63'd0;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    // Architectural state is updated in one step at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soc_reg             <= chgsup_pkg::SOC_UNKNOWN;
            seen_reg            <= chgsup_pkg::PROF_NONE;
            applied_reg         <= chgsup_pkg::PROF_NONE;
            have_time_reg       <= 1'b0;
            last_power_time_reg <= 32'd0;
            last_attempt_reg    <= 32'd0;
            last_kick_reg       <= 32'd0;
            unk_energy_reg      <= 63'd0;
            chg_energy_reg      <= 63'd0;
            idle_energy_reg     <= 63'd0;
            fail_reg            <= 1'b0;
            held_power_reg      <= 31'd0;
        end
        else if (cmd.commit)
        begin
            soc_reg         <= soc_new_reg;
            seen_reg        <= seen_next;
            applied_reg     <= applied_next;
            unk_energy_reg  <= unk_energy_next;
            chg_energy_reg  <= chg_energy_next;
            idle_energy_reg <= idle_energy_next;
            fail_reg        <= fail_next;
            held_power_reg  <= held_power_next;
            if (pw_en)
            begin
                have_time_reg       <= 1'b1;
                last_power_time_reg <= item_reg.timestamp_ms;
            end
            if (apply_go)
            begin
                last_attempt_reg <= item_reg.timestamp_ms;
            end
            if ((apply_go && item_reg.driver_ok) || kick_go)
            begin
                last_kick_reg <= item_reg.timestamp_ms;
            end
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

[src/charge_supervisor.sv]
// Charge supervisor: takes measurement samples and returns charge state,
// power, energy bins and charger commands per sample.
// The input sample stream (s_*) carries one measurement per transaction.
// The result stream (m_*) returns exactly one result per sample.
// The write port (cfg_*) sets thresholds and intervals; write only while idle.
// A sample passes through the decode step (16x15 power product), the multiply
// step (31x32 energy product) and the accumulate step, which commits the result
// once the output register is free or being drained.
// s_tready is high only in the idle step, so a new sample is taken only after the last one is committed.
// The result sits in an output register, so the next sample is taken while
// a finished result waits; if the receiver still stalls when the following
// result is ready, the block holds it and keeps s_tready low until drained.
// Reset (rst_n low, asynchronous) restores register defaults, clears all
// energy bins and history, and drops m_tvalid. No clearing pass is needed.
// Depends on chgsup_pkg, chgsup_ctrl and chgsup_datapath.
`default_nettype none

module charge_supervisor (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // timestamp_ms, updated_sources, valid_sources, status_port_byte,
    // output_voltage_mv, output_current_ma, input1_voltage_mv,
    // input2_voltage_mv, driver_ok, one zero pad bit
    input  wire logic [chgsup_pkg::IN_W-1:0]        s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // charge_state, charge_indicator, detected_profile, configured_profile,
    // apply_profile_cmd, watchdog_kick_cmd, power_uw, unknown_energy,
    // charging_energy, idle_energy, command_failed
    output logic [chgsup_pkg::OUT_W-1:0]            m_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_we,
    input  wire logic [chgsup_pkg::CFG_AW-1:0]      cfg_addr,
    input  wire logic [chgsup_pkg::CFG_DW-1:0]      cfg_wdata
);

    chgsup_pkg::cmd_t      cmd;
    chgsup_pkg::in_item_t  in_item;
    chgsup_pkg::out_item_t out_item;

    assign in_item = s_tdata;
    assign m_tdata = out_item;

    chgsup_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    chgsup_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .in_item   (in_item),
        .out_item  (out_item)
    );

`ifndef ASSERT_OFF
    // A sample occupies the block for the decode and multiply steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (!s_tready ##1 !s_tready))
        else $error("sample accepted while previous one still in flight");

    // A profile application and a watchdog kick never share one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[9:8] == chgsup_pkg::PROF_NONE) || !m_tdata[10]))
        else $error("apply and kick commanded together");

    // The indicator follows the charging state exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3] == (m_tdata[2:0] == chgsup_pkg::SOC_CHARGING)))
        else $error("indicator disagrees with charge state");

    // A successful application shows up as the configured profile.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[9:8] != chgsup_pkg::PROF_NONE) && !m_tdata[231])
        |-> (m_tdata[7:6] == m_tdata[9:8]))
        else $error("applied profile not recorded");
`endif

endmodule

`default_nettype wire
